FILE: src/slg_pkg.sv
// ----------------------------------------------------------------------------
// slg_pkg
// Shared types and constants for the surface lattice grid point block.
// ----------------------------------------------------------------------------
package slg_pkg;

    localparam int unsigned CNT_W       = 11;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned FRAC_W      = 16;
    localparam int unsigned COORD_W     = 32;
    localparam int unsigned B1_W        = 41;
    localparam int unsigned MAX_DENSITY = 1024;

    // fraction divider: stages and quotient bits resolved per stage
    localparam int unsigned DIV_STAGES  = 4;
    localparam int unsigned DIV_BITS    = FRAC_W / DIV_STAGES;

    // configuration register indexes
    localparam logic [2:0] REG_LAT_A_X = 3'd0;
    localparam logic [2:0] REG_LAT_A_Y = 3'd1;
    localparam logic [2:0] REG_LAT_A_Z = 3'd2;
    localparam logic [2:0] REG_LAT_B_X = 3'd3;
    localparam logic [2:0] REG_LAT_B_Y = 3'd4;
    localparam logic [2:0] REG_LAT_B_Z = 3'd5;
    localparam logic [2:0] REG_A_COUNT = 3'd6;
    localparam logic [2:0] REG_B_COUNT = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0]          a_index;
        logic [IDX_W-1:0]          b_index;
        logic signed [COORD_W-1:0] cleavage;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]          a_step;
        logic [IDX_W-1:0]          b_step;
        logic [FRAC_W-1:0]         a_fraction;
        logic [FRAC_W-1:0]         b_fraction;
        logic signed [COORD_W-1:0] x_pos;
        logic signed [COORD_W-1:0] y_pos;
        logic signed [COORD_W-1:0] cleavage_out;
        logic                      bad_input;
    } t_out_item;

    // planar frame and grid counts, stable while items flow
    typedef struct packed {
        logic [COORD_W-1:0] a1;
        logic [B1_W-1:0]    b1_mag;
        logic               b1_neg;
        logic [COORD_W-1:0] b2;
        logic               a_zero;
        logic [CNT_W-1:0]   a_count;
        logic [CNT_W-1:0]   b_count;
    } t_geom;

    function automatic logic [31:0] mag32(logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

FILE: src/slg_isqrt.sv
// ----------------------------------------------------------------------------
// slg_isqrt
// Iterative integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module slg_isqrt
    import slg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [63:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

FILE: src/slg_geom.sv
// ----------------------------------------------------------------------------
// slg_geom
// Configuration registers and the sequencer that derives a1, b1 and b2.
// ----------------------------------------------------------------------------
module slg_geom
    import slg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_busy,
    output t_geom       o_geom
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SQA  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SQ   = 3'd4;
    localparam logic [2:0] S_RAD  = 3'd5;
    localparam logic [2:0] S_SQB  = 3'd6;

    logic [31:0]      r_a [3];
    logic [31:0]      r_b [3];
    logic [CNT_W-1:0] r_a_count;
    logic [CNT_W-1:0] r_b_count;

    logic [2:0]       r_state;
    logic [3:0]       r_cnt;
    logic [5:0]       r_dcnt;
    logic [63:0]      r_aa, r_bb, r_pos, r_neg;
    logic [63:0]      r_prod;
    logic [3:0]       r_pcnt;
    logic             r_pv;
    logic             r_psign;
    logic [31:0]      r_a1;
    logic [B1_W-1:0]  r_b1_mag;
    logic             r_b1_neg;
    logic [31:0]      r_b2;
    logic [31:0]      r_rem;
    logic [63:0]      r_quo;

    logic [1:0]       k;
    logic [31:0]      mx, my;
    logic             msign;
    logic             sq_start;
    logic [63:0]      sq_value;
    logic             sq_done;
    logic [31:0]      sq_root;
    logic [32:0]      rem_sh;
    logic             ge;
    logic [63:0]      quo_nx;
    logic [63:0]      rad;

    always_comb begin
        case (r_cnt) inside
            [4'd0:4'd2]: k = r_cnt[1:0];
            [4'd3:4'd5]: k = 2'(r_cnt - 4'd3);
            default:     k = 2'(r_cnt - 4'd6);
        endcase
        mx    = '0;
        my    = '0;
        msign = 1'b0;
        if (r_state == S_MUL) begin
            case (r_cnt) inside
                [4'd0:4'd2]: begin
                    mx = mag32(r_a[k]);
                    my = mx;
                end
                [4'd3:4'd5]: begin
                    mx = mag32(r_b[k]);
                    my = mx;
                end
                [4'd6:4'd8]: begin
                    mx    = mag32(r_a[k]);
                    my    = mag32(r_b[k]);
                    msign = r_a[k][31] ^ r_b[k][31];
                end
                default: begin
                    mx = '0;
                end
            endcase
        end else if (r_state == S_SQ) begin
            mx = r_b1_mag[31:0];
            my = r_b1_mag[31:0];
        end
    end

    // divider step: restoring, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[63]};
    assign ge     = rem_sh >= {1'b0, r_a1};
    assign quo_nx = {r_quo[62:0], ge};

    always_comb begin
        if (r_b1_mag[B1_W-1:32] != '0) begin
            rad = '0;
        end else begin
            rad = (r_bb > r_prod) ? (r_bb - r_prod) : '0;
        end
    end

    assign sq_start = ((r_state == S_MUL) && (r_cnt == 4'd10)) || (r_state == S_RAD);
    assign sq_value = (r_state == S_RAD) ? rad : r_aa;

    slg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mx) * 64'(my);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a[0]    <= 32'h0001_0000;
            r_a[1]    <= '0;
            r_a[2]    <= '0;
            r_b[0]    <= '0;
            r_b[1]    <= 32'h0001_0000;
            r_b[2]    <= '0;
            r_a_count <= CNT_W'(1);
            r_b_count <= CNT_W'(1);
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_dcnt    <= '0;
            r_pv      <= 1'b0;
            r_a1      <= 32'h0001_0000;
            r_b1_mag  <= '0;
            r_b1_neg  <= 1'b0;
            r_b2      <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LAT_A_X: r_a[0]    <= i_cfg_data;
                REG_LAT_A_Y: r_a[1]    <= i_cfg_data;
                REG_LAT_A_Z: r_a[2]    <= i_cfg_data;
                REG_LAT_B_X: r_b[0]    <= i_cfg_data;
                REG_LAT_B_Y: r_b[1]    <= i_cfg_data;
                REG_LAT_B_Z: r_b[2]    <= i_cfg_data;
                REG_A_COUNT: r_a_count <= i_cfg_data[CNT_W-1:0];
                REG_B_COUNT: r_b_count <= i_cfg_data[CNT_W-1:0];
                default:     r_a_count <= r_a_count;
            endcase
            // restart the frame computation from scratch
            r_state <= S_MUL;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_aa    <= '0;
            r_bb    <= '0;
            r_pos   <= '0;
            r_neg   <= '0;
        end else begin
            r_pv    <= 1'b0;
            if (r_pv) begin
                case (r_pcnt) inside
                    [4'd0:4'd2]: r_aa <= r_aa + r_prod;
                    [4'd3:4'd5]: r_bb <= r_bb + r_prod;
                    default: begin
                        if (r_psign) begin
                            r_neg <= r_neg + r_prod;
                        end else begin
                            r_pos <= r_pos + r_prod;
                        end
                    end
                endcase
            end
            case (r_state)
                S_MUL: begin
                    r_pv    <= (r_cnt < 4'd9);
                    r_pcnt  <= r_cnt;
                    r_psign <= msign;
                    r_cnt   <= r_cnt + 4'd1;
                    if (r_cnt == 4'd10) begin
                        r_state <= S_SQA;
                    end
                end
                S_SQA: begin
                    if (sq_done) begin
                        r_a1 <= sq_root;
                        if (sq_root == '0) begin
                            r_b1_mag <= '0;
                            r_b1_neg <= 1'b0;
                            r_state  <= S_SQ;
                        end else begin
                            r_b1_neg <= r_neg > r_pos;
                            r_quo    <= (r_neg > r_pos) ? (r_neg - r_pos) : (r_pos - r_neg);
                            r_rem    <= '0;
                            r_dcnt   <= '0;
                            r_state  <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= ge ? 32'(rem_sh - {1'b0, r_a1}) : rem_sh[31:0];
                    r_quo  <= quo_nx;
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd63) begin
                        // cap the magnitude at 2^40
                        if ((quo_nx[63:B1_W] != '0) ||
                            (quo_nx[B1_W-1] && (quo_nx[B1_W-2:0] != '0))) begin
                            r_b1_mag <= {1'b1, {(B1_W-1){1'b0}}};
                        end else begin
                            r_b1_mag <= quo_nx[B1_W-1:0];
                        end
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_state <= S_RAD;
                end
                S_RAD: begin
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    if (sq_done) begin
                        r_b2    <= sq_root;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_geom.a1      = r_a1;
    assign o_geom.b1_mag  = r_b1_mag;
    assign o_geom.b1_neg  = r_b1_neg;
    assign o_geom.b2      = r_b2;
    assign o_geom.a_zero  = (r_a1 == '0);
    assign o_geom.a_count = r_a_count;
    assign o_geom.b_count = r_b_count;

endmodule

FILE: src/slg_pipe.sv
// ----------------------------------------------------------------------------
// slg_pipe
// Per-item pipeline: fraction division, frame multiply, round and saturate.
// ----------------------------------------------------------------------------
module slg_pipe
    import slg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    input  t_geom     i_geom,
    output logic      o_valid,
    output t_out_item o_item
);

    typedef struct packed {
        logic [IDX_W-1:0]   ia;
        logic [IDX_W-1:0]   ib;
        logic [31:0]        cleavage;
        logic [CNT_W-1:0]   ca;
        logic [CNT_W-1:0]   cb;
        logic [CNT_W-1:0]   rem_a;
        logic [CNT_W-1:0]   rem_b;
        logic [FRAC_W-1:0]  q_a;
        logic [FRAC_W-1:0]  q_b;
        logic               sat_a;
        logic               sat_b;
        logic               zero_a;
        logic               zero_b;
        logic               bad;
    } t_dst;

    typedef struct packed {
        logic [IDX_W-1:0]   ia;
        logic [IDX_W-1:0]   ib;
        logic [FRAC_W-1:0]  fa;
        logic [FRAC_W-1:0]  fb;
        logic [31:0]        cleavage;
        logic               bad;
        logic [47:0]        ta;
        logic [56:0]        tb;
        logic [47:0]        ty;
    } t_mst;

    logic             r_dv [DIV_STAGES+1];
    t_dst             r_ds [DIV_STAGES+1];
    logic             r_mv;
    t_mst             r_ms;
    logic             r_ov;
    t_out_item        r_out;

    t_dst             s0;
    logic [CNT_W-1:0] ca, cb;
    t_dst             last;
    logic [FRAC_W-1:0] fa, fb;
    logic signed [59:0] sx;
    logic signed [59:0] tx;
    logic signed [43:0] rx;
    logic [48:0]      tyr;
    logic [32:0]      ry;
    logic [31:0]      x_sat, y_sat;

    // DIV_BITS quotient bits per stage
    function automatic t_dst div_step(t_dst s);
        t_dst        o;
        logic [11:0] ra;
        logic [11:0] rb;
        logic        ga;
        logic        gb;
        o = s;
        for (int n = 0; n < DIV_BITS; n++) begin
            ra = {o.rem_a, 1'b0};
            rb = {o.rem_b, 1'b0};
            ga = ra >= {1'b0, o.ca};
            gb = rb >= {1'b0, o.cb};
            if (ga) begin
                ra = ra - {1'b0, o.ca};
            end
            if (gb) begin
                rb = rb - {1'b0, o.cb};
            end
            o.rem_a = ra[CNT_W-1:0];
            o.rem_b = rb[CNT_W-1:0];
            o.q_a   = {o.q_a[FRAC_W-2:0], ga};
            o.q_b   = {o.q_b[FRAC_W-2:0], gb};
        end
        return o;
    endfunction

    // clamp counts at the density limit, flag out-of-range indexes and a zero a-vector
    always_comb begin
        ca = (i_geom.a_count > CNT_W'(MAX_DENSITY)) ? CNT_W'(MAX_DENSITY) : i_geom.a_count;
        cb = (i_geom.b_count > CNT_W'(MAX_DENSITY)) ? CNT_W'(MAX_DENSITY) : i_geom.b_count;
        s0.ia       = i_item.a_index;
        s0.ib       = i_item.b_index;
        s0.cleavage = i_item.cleavage;
        s0.ca       = ca;
        s0.cb       = cb;
        s0.rem_a    = CNT_W'(i_item.a_index);
        s0.rem_b    = CNT_W'(i_item.b_index);
        s0.q_a      = '0;
        s0.q_b      = '0;
        s0.sat_a    = CNT_W'(i_item.a_index) >= ca;
        s0.sat_b    = CNT_W'(i_item.b_index) >= cb;
        s0.zero_a   = (ca == '0);
        s0.zero_b   = (cb == '0);
        s0.bad      = i_geom.a_zero ||
                      (CNT_W'(i_item.a_index) >= i_geom.a_count) ||
                      (CNT_W'(i_item.b_index) >= i_geom.b_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                r_dv[s] <= 1'b0;
            end
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_dv[0] <= i_valid;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_dv[s+1] <= r_dv[s];
            end
            r_mv <= r_dv[DIV_STAGES];
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ds[0] <= s0;
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_ds[s+1] <= div_step(r_ds[s]);
        end
    end

    assign last = r_ds[DIV_STAGES];
    assign fa = last.zero_a ? '0 : (last.sat_a ? '1 : last.q_a);
    assign fb = last.zero_b ? '0 : (last.sat_b ? '1 : last.q_b);

    always_ff @(posedge i_clk) begin
        r_ms.ia       <= last.ia;
        r_ms.ib       <= last.ib;
        r_ms.fa       <= fa;
        r_ms.fb       <= fb;
        r_ms.cleavage <= last.cleavage;
        r_ms.bad      <= last.bad;
        r_ms.ta       <= 48'(i_geom.a1) * 48'(fa);
        r_ms.tb       <= 57'(i_geom.b1_mag) * 57'(fb);
        r_ms.ty       <= 48'(i_geom.b2) * 48'(fb);
    end

    // round half up to Q16.16, then saturate
    always_comb begin
        sx = i_geom.b1_neg ? ($signed(60'(r_ms.ta)) - $signed(60'(r_ms.tb)))
                           : ($signed(60'(r_ms.ta)) + $signed(60'(r_ms.tb)));
        tx = sx + 60'sd32768;
        rx = 44'(tx >>> FRAC_W);
        if ((rx[43:31] == '0) || (rx[43:31] == '1)) begin
            x_sat = rx[31:0];
        end else if (rx[43]) begin
            x_sat = 32'h8000_0000;
        end else begin
            x_sat = 32'h7FFF_FFFF;
        end
        tyr = 49'(r_ms.ty) + 49'd32768;
        ry  = tyr[48:FRAC_W];
        y_sat = (ry[32:31] != 2'b00) ? 32'h7FFF_FFFF : ry[31:0];
    end

    always_ff @(posedge i_clk) begin
        r_out.a_step       <= r_ms.ia;
        r_out.b_step       <= r_ms.ib;
        r_out.a_fraction   <= r_ms.fa;
        r_out.b_fraction   <= r_ms.fb;
        r_out.x_pos        <= x_sat;
        r_out.y_pos        <= y_sat;
        r_out.cleavage_out <= r_ms.cleavage;
        r_out.bad_input    <= r_ms.bad;
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

endmodule

FILE: src/surface_lattice_grid_point_top.sv
// ----------------------------------------------------------------------------
// surface_lattice_grid_point_top
// Grid point generator on a planar frame built from two lattice vectors.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                              | Handshake
//  ---------+------------------------------------+------------------------------
//  item in  | start, i_item                      | taken when start && !busy
//  result   | o_strobe, o_item                   | one-cycle strobe, no stall
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data    | written when i_cfg_we is high
//
//  One item is taken per cycle while busy is low; its result reaches the
//  result ports through the entry register (loaded at the accepting edge),
//  four division stages of four quotient bits each, one multiply stage and
//  one round/saturate stage into the output register. Every config write
//  restarts the frame sequencer, which holds busy high until the frame is
//  rebuilt: nine products and the square of b1 on one 32x32 multiplier, two
//  32-step square roots and a 64-step divide (the divide is skipped for a
//  zero a-vector). Reset loads the default vectors and their frame at once,
//  so busy is low after reset. The result side cannot stall, so nothing ever
//  backs up into the pipeline.
//
module surface_lattice_grid_point_top
    import slg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_strobe,
    output t_out_item   o_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_geom geom;
    logic  geom_busy;
    logic  accept;

    // frame registers and their sequencer
    slg_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_busy     (geom_busy),
        .o_geom     (geom)
    );

    // hold off items only while the frame is being recomputed
    assign busy   = geom_busy;
    assign accept = start && !geom_busy;

    slg_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .i_geom  (geom),
        .o_valid (o_strobe),
        .o_item  (o_item)
    );

endmodule

FILE: dv/tb_surface_lattice_grid_point_top.sv
// ----------------------------------------------------------------------------
// tb_surface_lattice_grid_point_top
// Self-checking bench for the surface lattice grid point block: it programs a
// series of lattice frames and grid counts, streams grid items through the
// item port and checks every result against an in-bench point predictor.
// ----------------------------------------------------------------------------
module tb_surface_lattice_grid_point_top;
    import slg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PIPE_DRAIN = 12;
    localparam int unsigned STALL_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_item = '0;
    logic        o_strobe;
    t_out_item   o_item;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = REG_LAT_A_X;
    logic [31:0] i_cfg_data = '0;

    surface_lattice_grid_point_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the register file, masked as the block stores it.
    logic [31:0] lattice_reg [8];
    t_in_item    pending_items [$];
    t_out_item   expected_points [$];
    bit          sender_idles = 1'b1;
    int unsigned fail_count = 0;
    int unsigned items_sent = 0;
    int unsigned points_checked = 0;
    int unsigned bad_seen = 0;
    int unsigned frames_run = 0;

    // Append to the tail of the sender and expected queues.
    function automatic void add_pending(t_in_item it);
        pending_items = {pending_items, it};
    endfunction

    function automatic void add_expected(t_out_item p);
        expected_points = {expected_points, p};
    endfunction

    // ------------------------------------------------------------------------
    // Point predictor
    // ------------------------------------------------------------------------
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned grid_fraction(longint unsigned idx,
                                                      longint unsigned cnt);
        longint unsigned c = (cnt > MAX_DENSITY) ? MAX_DENSITY : cnt;
        longint unsigned q;
        if (c == 0) return 0;
        q = (idx << 16) / c;
        return (q > 65535) ? 65535 : q;
    endfunction

    // Round half up from Q.32 to Q16.16, then clamp to 32-bit signed.
    function automatic logic [31:0] round_clamp(longint s);
        longint r = (s + 64'sd32768) >>> 16;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic t_out_item predict_point(t_in_item it);
        t_out_item       p;
        longint          av, bv, prod, sx;
        longint unsigned aa = 0, bb = 0, pos = 0, neg = 0;
        longint unsigned a1, b1m = 0, rad, b2, fa, fb, dm;
        bit              b1n = 1'b0;
        for (int k = 0; k < 3; k++) begin
            av = longint'($signed(lattice_reg[k]));
            bv = longint'($signed(lattice_reg[k+3]));
            aa += longint'(av < 0 ? -av : av) * longint'(av < 0 ? -av : av);
            bb += longint'(bv < 0 ? -bv : bv) * longint'(bv < 0 ? -bv : bv);
            prod = av * bv;
            if (prod < 0) neg += -prod;
            else pos += prod;
        end
        a1 = root_floor(aa);
        if (a1 != 0) begin
            b1n = neg > pos;
            dm  = b1n ? neg - pos : pos - neg;
            b1m = dm / a1;
            if (b1m > (64'd1 << 40)) b1m = 64'd1 << 40;
        end
        if (b1m >= (64'd1 << 32)) rad = 0;
        else rad = (bb > b1m * b1m) ? bb - b1m * b1m : 0;
        b2 = root_floor(rad);
        fa = grid_fraction(it.a_index, lattice_reg[REG_A_COUNT]);
        fb = grid_fraction(it.b_index, lattice_reg[REG_B_COUNT]);
        sx = longint'(a1 * fa) + (b1n ? -longint'(b1m * fb) : longint'(b1m * fb));
        p.a_step       = it.a_index;
        p.b_step       = it.b_index;
        p.a_fraction   = fa[15:0];
        p.b_fraction   = fb[15:0];
        p.x_pos        = round_clamp(sx);
        p.y_pos        = round_clamp(longint'(b2 * fb));
        p.cleavage_out = it.cleavage;
        p.bad_input    = (a1 == 0) || (it.a_index >= lattice_reg[REG_A_COUNT])
                      || (it.b_index >= lattice_reg[REG_B_COUNT]);
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: hold start until the item is taken, idle at random between items
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                add_expected(predict_point(i_item));
                items_sent++;
            end
            if (!start || !busy) begin
                if (pending_items.size() > 0 &&
                    !(sender_idles && $urandom_range(99) < 20)) begin
                    i_item <= pending_items.pop_front();
                    start  <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every strobe must match the oldest predicted point
    // ------------------------------------------------------------------------
    task automatic field_error(string fname, longint unsigned e, longint unsigned a);
        $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, fname, e, a);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_strobe) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0h",
                         $realtime, o_item);
                fail_count++;
            end else begin
                e = expected_points.pop_front();
                points_checked++;
                if (o_item.bad_input) bad_seen++;
                if (o_item.a_step != e.a_step)
                    field_error("a_step", e.a_step, o_item.a_step);
                if (o_item.b_step != e.b_step)
                    field_error("b_step", e.b_step, o_item.b_step);
                if (o_item.a_fraction != e.a_fraction)
                    field_error("a_fraction", e.a_fraction, o_item.a_fraction);
                if (o_item.b_fraction != e.b_fraction)
                    field_error("b_fraction", e.b_fraction, o_item.b_fraction);
                if (o_item.x_pos != e.x_pos)
                    field_error("x_pos", e.x_pos, o_item.x_pos);
                if (o_item.y_pos != e.y_pos)
                    field_error("y_pos", e.y_pos, o_item.y_pos);
                if (o_item.cleavage_out != e.cleavage_out)
                    field_error("cleavage_out", e.cleavage_out, o_item.cleavage_out);
                if (o_item.bad_input !== e.bad_input)
                    field_error("bad_input", e.bad_input, o_item.bad_input);
            end
        end
    end

    // Watchdog: count cycles with no item taken, no result and no write.
    int unsigned quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------------
    // Hold until the sender is empty and every predicted point has come out.
    task automatic drain_all();
        while (pending_items.size() > 0 || start || expected_points.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_frame(logic [31:0] v [8]);
        drain_all();
        for (int r = 0; r < 8; r++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= r[2:0];
            i_cfg_data <= v[r];
            lattice_reg[r] = (r >= REG_A_COUNT) ? {21'd0, v[r][10:0]} : v[r];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        frames_run++;
    endtask

    function automatic logic [9:0] pick_index(logic [31:0] cnt);
        if ($urandom_range(99) < 15 || cnt == 0) return 10'($urandom_range(1023));
        return 10'($urandom_range((cnt > 1024 ? 1024 : cnt) - 1));
    endfunction

    task automatic queue_points(int unsigned n);
        t_in_item it;
        repeat (n) begin
            it.a_index  = pick_index(lattice_reg[REG_A_COUNT]);
            it.b_index  = pick_index(lattice_reg[REG_B_COUNT]);
            it.cleavage = $urandom;
            add_pending(it);
        end
    endtask

    task automatic queue_one(logic [9:0] ai, logic [9:0] bi, logic [31:0] cl);
        t_in_item it;
        it.a_index  = ai;
        it.b_index  = bi;
        it.cleavage = cl;
        add_pending(it);
    endtask

    initial begin
        logic [31:0] f [8];
        lattice_reg = '{32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 1, 1};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset frame: unit square, one division each way; indices at edges.
        queue_one(0, 0, 32'h0000_0000);
        queue_one(0, 0, 32'h7FFF_FFFF);
        queue_one(0, 0, 32'h8000_0000);
        queue_one(0, 0, 32'hFFFF_FFFF);
        queue_one(1, 0, 32'h0001_0000);
        queue_one(0, 1, 32'h5555_5555);
        queue_one(1023, 1023, 32'hAAAA_AAAA);
        queue_one(1023, 0, 32'h0000_0001);

        // Skewed frame at full rate: drop idling for the whole phase.
        f = '{32'h0002_0000, 32'h0000_8000, 32'hFFFF_0000,
              32'h0000_8000, 32'h0001_BB68, 32'h0000_4000, 16, 10};
        write_frame(f);
        sender_idles = 1'b0;
        queue_one(15, 9, 0);
        queue_one(16, 10, 0);
        queue_points(100);
        drain_all();
        sender_idles = 1'b1;

        // Zero a-vector: every point bad, b2 falls back to |b|.
        f = '{0, 0, 0, 32'hFFFE_0000, 32'h0003_0000, 32'h0001_0000, 1024, 1024};
        write_frame(f);
        queue_one(1023, 1023, 0);
        queue_points(100);

        // Most negative components, single division.
        f = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1};
        write_frame(f);
        queue_points(100);

        // Most positive components, zero a count, oversized b count.
        f = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 2047};
        write_frame(f);
        queue_points(100);

        // Antiparallel vectors: b1 negative, b2 clamps to zero.
        f = '{32'h0003_0000, 32'h0004_0000, 0,
              32'hFFFA_0000, 32'hFFF8_0000, 0, 1024, 7};
        write_frame(f);
        queue_points(100);

        // Random frames: a couple at full range, the rest at modest scale.
        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < 6; r++)
                f[r] = (ph < 2) ? $urandom
                                : 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
            f[REG_A_COUNT] = (ph == 3) ? $urandom : $urandom_range(1024, 1);
            f[REG_B_COUNT] = (ph == 4) ? $urandom : $urandom_range(1024, 1);
            write_frame(f);
            queue_points(100);
        end

        drain_all();
        $display("checked %0d grid points (%0d flagged bad) across %0d lattice frames",
                 points_checked, bad_seen, frames_run + 1);
        $display("frames included zero, extreme and antiparallel vectors and zero to oversize counts");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/slg_pkg.sv
src/slg_isqrt.sv
src/slg_geom.sv
src/slg_pipe.sv
src/surface_lattice_grid_point_top.sv
dv/tb_surface_lattice_grid_point_top.sv
